[hw/rtl/sulst_pkg.sv]
// Shared types and constants for the sorted unique key list.
`default_nettype none

package sulst_pkg;

  // Width of the key and removed-key ports
  localparam int unsigned KEY_W = 16;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP_MIN = 2'd1,
    CMD_POP_MAX = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DUP   = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert key at its sorted place
    logic shl;  // shift every key one cell toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/sulst_cell.sv]
// One cell of the sorted key chain: holds one key, compares it, shifts.
`default_nettype none

module sulst_cell #(
  parameter int unsigned KeyW = 16
) (
  input  wire                     clk_i,
  input  wire sulst_pkg::cell_ctrl_t ctrl_i,
  input  wire  [KeyW-1:0]         key_i,       // broadcast key
  input  wire                     occ_i,       // this cell holds a live key
  input  wire  [KeyW-1:0]         left_key_i,
  input  wire                     left_lt_i,   // left neighbor below key
  input  wire  [KeyW-1:0]         right_key_i,
  output logic [KeyW-1:0]         key_o,
  output logic                    lt_o,        // live and below key
  output logic                    hit_o        // live and equal to key
);

  logic [KeyW-1:0] key_q, key_d;

  assign key_o = key_q;
  assign lt_o  = occ_i && (key_q < key_i);
  assign hit_o = occ_i && (key_q == key_i);

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins) begin
      if (!lt_o) begin
        // first cell at or above the key takes it, the rest move right
        key_d = left_lt_i ? key_i : left_key_i;
      end
    end else if (ctrl_i.shl) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

[hw/rtl/sorted_unique_key_list.sv]
// Top level of the sorted unique key list: cell chain, count and result register.
// Latency: the result of a transaction is presented the cycle after it is accepted.
// Throughput: one transaction per cycle unless out_ready_i stalls; every cell
//   compares against the key in parallel and updates at the same edge.
// Reset: count and output valid clear asynchronously; stored keys are not reset,
//   only cells below the count are ever read.
`default_nettype none

module sorted_unique_key_list #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // command channel
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire  [1:0]                             command_i,
  input  wire  [sulst_pkg::KEY_W-1:0]            key_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic [1:0]                             status_o,
  output logic [sulst_pkg::KEY_W-1:0]            removed_key_o,
  output logic [$clog2(CAPACITY+1)-1:0]          count_o
);

  // Effective stored key width: the port carries at most KEY_W bits
  localparam int unsigned KeyW =
    (KEY_BITS < sulst_pkg::KEY_W) ? KEY_BITS : sulst_pkg::KEY_W;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // ---------------------------------------------------------------------------
  // Handshake: the output register frees up when empty or when taken.
  // ---------------------------------------------------------------------------
  logic accept;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  sulst_pkg::cmd_e cmd;
  logic [KeyW-1:0] key_m;

  assign cmd   = sulst_pkg::cmd_e'(command_i);
  assign key_m = key_i[KeyW-1:0];

  // ---------------------------------------------------------------------------
  // Cell chain. Cell 0 holds the smallest key. occ[i] marks cells below count.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]           count_q, count_d;
  logic [CAPACITY-1:0]       occ, lt, hit;
  logic [KeyW-1:0]           cell_key [CAPACITY];
  sulst_pkg::cell_ctrl_t     ctrl;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KeyW-1:0] left_key;
    logic            left_lt;
    logic [KeyW-1:0] right_key;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_key = '0;
      assign left_lt  = 1'b1;  // nothing sits in front of the head
    end else begin : g_body
      assign left_key = cell_key[i-1];
      assign left_lt  = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = '0;
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    sulst_cell #(
      .KeyW (KeyW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .key_i       (key_m),
      .occ_i       (occ[i]),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .lt_o        (lt[i]),
      .hit_o       (hit[i])
    );
  end

  // Largest key: the last occupied cell, picked by an AND-OR select
  logic [KeyW-1:0] max_key;

  always_comb begin
    max_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (occ[i] && ((i == CAPACITY - 1) || !occ[(i + 1) % CAPACITY])) begin
        max_key = max_key | cell_key[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command decode and result.
  // ---------------------------------------------------------------------------
  logic             dup, full, empty;
  sulst_pkg::status_e status_d;
  logic [KeyW-1:0]  removed_d;

  assign dup   = |hit;
  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    ctrl      = '0;
    status_d  = sulst_pkg::ST_OK;
    removed_d = '0;
    count_d   = count_q;
    case (cmd)
      sulst_pkg::CMD_INSERT: begin
        if (dup) begin
          status_d = sulst_pkg::ST_DUP;       // checked before full
        end else if (full) begin
          status_d = sulst_pkg::ST_FULL;
        end else begin
          ctrl.ins = accept;
          count_d  = count_q + 1'b1;
        end
      end
      sulst_pkg::CMD_POP_MIN: begin
        if (empty) begin
          status_d = sulst_pkg::ST_EMPTY;
        end else begin
          ctrl.shl  = accept;
          removed_d = cell_key[0];
          count_d   = count_q - 1'b1;
        end
      end
      sulst_pkg::CMD_POP_MAX: begin
        if (empty) begin
          status_d = sulst_pkg::ST_EMPTY;
        end else begin
          removed_d = max_key;
          count_d   = count_q - 1'b1;
        end
      end
      sulst_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Count and output register.
  // ---------------------------------------------------------------------------
  logic [1:0]                  status_q;
  logic [sulst_pkg::KEY_W-1:0] removed_q;
  logic [CntW-1:0]             count_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      removed_q   <= sulst_pkg::KEY_W'(removed_d);
      count_out_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign removed_key_o = removed_q;
  assign count_o       = count_out_q;

endmodule

`default_nettype wire
